// ===== src/dsr_pkg.sv =====
// Shared types and constants for the double-to-single rounding block.
package dsr_pkg;

    localparam logic [10:0] EXP_TINY_LIMIT   = 11'd897;
    localparam logic [10:0] EXP_OVF_LIMIT    = 11'd1150;
    localparam logic [10:0] EXP_NORMAL_LIMIT = 11'd1151;
    localparam logic [10:0] EXP_ALL_ONES     = 11'd2047;
    localparam logic [63:0] MAX_SINGLE_POS   = 64'h47EF_FFFF_E000_0000;
    localparam logic [63:0] MAX_SINGLE_NEG   = 64'hC7EF_FFFF_E000_0000;
    localparam logic [63:0] INF_POS          = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] INF_NEG          = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT        = 64'h0008_0000_0000_0000;
    localparam logic [63:0] SINGLE_TRUNC     = 64'hFFFF_FFFF_E000_0000;

    localparam logic [1:0] RM_NEAREST = 2'd0;
    localparam logic [1:0] RM_ZERO    = 2'd1;
    localparam logic [1:0] RM_PINF    = 2'd2;
    localparam logic [1:0] RM_NINF    = 2'd3;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_VE   = 2'd1;
    localparam logic [1:0] CFG_UE   = 2'd2;
    localparam logic [1:0] CFG_OE   = 2'd3;

    localparam logic [3:0] CLS_PZERO  = 4'd0;
    localparam logic [3:0] CLS_PNORM  = 4'd2;
    localparam logic [3:0] CLS_PDENRM = 4'd4;
    localparam logic [3:0] CLS_PINF   = 4'd6;
    localparam logic [3:0] CLS_QNAN   = 4'd8;
    localparam logic [3:0] CLS_NONE   = 4'd9;

    typedef enum logic [2:0] {
        K_PASS, K_ZERO, K_TINY, K_NORMAL, K_OVF, K_INF, K_QNAN, K_SNAN
    } t_kind;

    typedef struct packed {
        logic [63:0] operand;
        t_kind       kind;
        logic        unsup;
        logic [1:0]  mode;
        logic        ve;
    } t_work;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  cls;
        logic        fr;
        logic        fi;
        logic        ux;
        logic        ox;
        logic        snan;
        logic        normal;
        logic        unsup;
        logic        denorm;
        logic        unord;
    } t_result;

endpackage

// ===== src/dsr_front.sv =====
// Front end: accepts operands, classifies them and pushes work into the queue.
module dsr_front import dsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_operand_value,
    input  logic [1:0]  i_mode,
    input  logic        i_ve,
    input  logic        i_ue,
    input  logic        i_oe,
    output logic        o_push,
    output t_work       o_work,
    input  logic        i_full
);
    logic [10:0] w_e;
    logic        w_magz;
    logic        w_fracz;
    t_kind       w_kind;
    logic        w_unsup;

    assign w_e     = i_operand_value[62:52];
    assign w_magz  = (i_operand_value[62:0] == 63'd0);
    assign w_fracz = (i_operand_value[51:0] == 52'd0);

    always_comb begin
        w_unsup = 1'b0;
        if (w_magz) begin
            w_kind = K_ZERO;
        end else if (w_e < EXP_TINY_LIMIT) begin
            w_kind  = K_TINY;
            w_unsup = i_ue;
        end else if (w_e < EXP_NORMAL_LIMIT) begin
            w_kind = K_NORMAL;
        end else if (w_e > EXP_OVF_LIMIT && w_e < EXP_ALL_ONES) begin
            w_kind  = K_OVF;
            w_unsup = i_oe;
        end else if (w_fracz) begin
            w_kind = K_INF;
        end else if (i_operand_value[51]) begin
            w_kind = K_QNAN;
        end else begin
            w_kind = K_SNAN;
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;
    assign o_work     = '{operand: i_operand_value, kind: w_kind, unsup: w_unsup,
                          mode: i_mode, ve: i_ve};

    logic w_unused;
    assign w_unused = i_clk ^ i_rst_n;
endmodule

// ===== src/dsr_queue.sv =====
// Two-entry queue between front end and back end.
module dsr_queue import dsr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_work,
    input  logic  i_pop
);
    t_work      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

// ===== src/dsr_back.sv =====
// Back end: rounds tiny operands, handles overflow, NaN and pass cases.
module dsr_back import dsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_work   i_work,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);
    logic [63:0] x;
    logic        sign;
    logic [10:0] e;
    logic [52:0] fr0;
    logic [10:0] n;
    logic [52:0] fsh;
    logic        g, rr, s;
    logic        lsb, gb, rb, xb, inc, any;
    logic [24:0] top;
    logic [23:0] mant;
    logic [23:0] norm;
    logic [4:0]  lz;
    logic        ovfm;
    logic [10:0] rexp;
    logic [52:0] lowmask;
    t_result     w_res;
    logic        r_valid;
    t_result     r_res;

    assign x    = i_work.operand;
    assign sign = x[63];
    assign e    = x[62:52];
    assign fr0  = {(e != 11'd0), x[51:0]};
    // shift to exponent -126: biased 897 is the floor; e=0 behaves as e=1
    assign n    = (e == 11'd0) ? 11'd896 : (EXP_TINY_LIMIT - e);
    assign fsh  = (n > 11'd53) ? 53'd0 : (fr0 >> n);

    always_comb begin
        // sticky covers every bit below the round bit
        lowmask = (n >= 11'd55) ? {53{1'b1}} : ((53'd1 << (n - 11'd2)) - 53'd1);
        g  = (n >= 11'd1) && (n <= 11'd53) && fr0[6'(n - 11'd1)];
        rr = (n >= 11'd2) && (n <= 11'd54) && fr0[6'(n - 11'd2)];
        s  = (n >= 11'd3) && ((fr0 & lowmask) != 53'd0);
        lsb = fsh[29];
        gb  = fsh[28];
        rb  = fsh[27];
        xb  = (fsh[26:0] != 27'd0) || g || rr || s;
        any = gb || rb || xb;
        unique case (i_work.mode)
            RM_NEAREST: inc = gb && (lsb || rb || xb);
            RM_PINF:    inc = !sign && any;
            RM_NINF:    inc = sign && any;
            default:    inc = 1'b0;
        endcase
        top  = {1'b0, fsh[52:29]} + {24'd0, inc};
        ovfm = top[24];
        mant = ovfm ? 24'h800000 : top[23:0];
        // leading-zero count: the highest set bit wins
        lz   = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (mant[i]) lz = 5'(23 - i);
        end
        norm = mant << lz;
        rexp = ovfm ? 11'd898 : (11'd897 - {6'd0, lz});
    end

    always_comb begin
        w_res       = '0;
        w_res.value = x;
        w_res.cls   = CLS_NONE;
        if (i_work.unsup) begin
            w_res.unsup = 1'b1;
        end else begin
            case (i_work.kind)
                K_ZERO: w_res.cls = {3'd0, sign};
                K_NORMAL: w_res.normal = 1'b1;
                K_INF: w_res.cls = CLS_PINF + {3'd0, sign};
                K_QNAN: begin
                    w_res.value = x & SINGLE_TRUNC;
                    w_res.cls   = CLS_QNAN;
                    w_res.unord = 1'b1;
                end
                K_SNAN: begin
                    w_res.snan = 1'b1;
                    if (!i_work.ve) begin
                        w_res.value = (x & SINGLE_TRUNC) | QUIET_BIT;
                        w_res.cls   = CLS_QNAN;
                        w_res.unord = 1'b1;
                    end
                end
                K_OVF: begin
                    w_res.ox = 1'b1;
                    w_res.fi = 1'b1;
                    unique case (i_work.mode)
                        RM_NEAREST: begin
                            w_res.value = sign ? INF_NEG : INF_POS;
                            w_res.cls   = CLS_PINF + {3'd0, sign};
                        end
                        RM_ZERO: begin
                            w_res.value = sign ? MAX_SINGLE_NEG : MAX_SINGLE_POS;
                            w_res.cls   = CLS_PNORM + {3'd0, sign};
                        end
                        RM_PINF: begin
                            w_res.value = sign ? MAX_SINGLE_NEG : INF_POS;
                            w_res.cls   = sign ? (CLS_PNORM + 4'd1) : CLS_PINF;
                        end
                        default: begin
                            w_res.value = sign ? INF_NEG : MAX_SINGLE_POS;
                            w_res.cls   = sign ? (CLS_PINF + 4'd1) : CLS_PNORM;
                        end
                    endcase
                end
                K_TINY: begin
                    w_res.ux = (fsh[28:0] != 29'd0) || g || rr || s;
                    w_res.fr = inc;
                    w_res.fi = any;
                    if (mant == 24'd0) begin
                        w_res.value = {sign, 63'd0};
                        w_res.cls   = {3'd0, sign};
                    end else begin
                        w_res.cls    = (mant[23] ? CLS_PNORM : CLS_PDENRM) + {3'd0, sign};
                        w_res.denorm = !mant[23];
                        w_res.value  = {sign, rexp, norm[22:0], 29'd0};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_pop       = i_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= w_res;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |=> r_valid && $stable(r_res))
        else $error("stalled result changed");
    a_unsup_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.unsup |-> r_res.cls == CLS_NONE)
        else $error("unsupported path with a class code");
endmodule

// ===== src/double_to_single_round_special_top.sv =====
// Top level of the double-to-single rounding block.
// Usage: operands enter on the input channel (i_in_valid / o_in_stall,
// i_operand_value); one result per operand leaves on the output channel
// (o_out_valid / i_out_stall) with the value, class code and status flags.
// Configuration registers (rounding mode, VE, UE, OE) are written through
// i_cfg_valid / o_cfg_ready with index and data; write only while idle.
// An accepted operand is classified combinationally by the front end and
// registered in a two-entry queue; the back end then rounds it into the
// output register, which drives o_out_valid.
// Throughput: one operand per cycle when the output is not stalled; the
// back end's single output register sets this rate.
// A stalled output holds its result; the queue absorbs two more operands
// before o_in_stall rises. Reset empties the queue, drops any pending
// result and clears all configuration registers to zero.
module double_to_single_round_special_top import dsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_value,
    output logic [3:0]  o_class_code,
    output logic        o_fraction_rounded,
    output logic        o_fraction_inexact,
    output logic        o_underflow_flag,
    output logic        o_overflow_flag,
    output logic        o_snan_flag,
    output logic        o_result_sign,
    output logic        o_needs_normal_path,
    output logic        o_unsupported_path,
    output logic        o_denormal_mark,
    output logic        o_unordered_mark,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);
    logic [1:0] r_mode;
    logic       r_ve, r_ue, r_oe;
    logic       w_push, w_full, w_qvalid, w_pop;
    t_work      w_fwork, w_qwork;
    t_result    w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RM_NEAREST;
            r_ve   <= 1'b0;
            r_ue   <= 1'b0;
            r_oe   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data;
                CFG_VE:   r_ve   <= i_cfg_data[0];
                CFG_UE:   r_ue   <= i_cfg_data[0];
                default:  r_oe   <= i_cfg_data[0];
            endcase
        end
    end

    dsr_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_operand_value,
        .i_mode(r_mode), .i_ve(r_ve), .i_ue(r_ue), .i_oe(r_oe),
        .o_push(w_push), .o_work(w_fwork), .i_full(w_full)
    );

    dsr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_work(w_fwork), .o_full(w_full),
        .o_valid(w_qvalid), .o_work(w_qwork), .i_pop(w_pop)
    );

    dsr_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qvalid), .i_work(w_qwork), .o_pop(w_pop),
        .o_out_valid, .i_out_stall, .o_res(w_res)
    );

    assign o_result_value      = w_res.value;
    assign o_class_code        = w_res.cls;
    assign o_fraction_rounded  = w_res.fr;
    assign o_fraction_inexact  = w_res.fi;
    assign o_underflow_flag    = w_res.ux;
    assign o_overflow_flag     = w_res.ox;
    assign o_snan_flag         = w_res.snan;
    assign o_result_sign       = w_res.value[63];
    assign o_needs_normal_path = w_res.normal;
    assign o_unsupported_path  = w_res.unsup;
    assign o_denormal_mark     = w_res.denorm;
    assign o_unordered_mark    = w_res.unord;
endmodule
